// ----- design/suk_pkg.sv -----
// Package for the sorted unique key table: item types, status codes and the
// wave record that walks the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package suk_pkg;

   localparam int unsigned DEFAULT_CAPACITY = 16;
   localparam int unsigned POS_OUT_W        = 4;
   localparam int unsigned COUNT_OUT_W      = 5;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_FOUND     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic               action;
      logic signed [31:0] key;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [POS_OUT_W-1:0]       match_position;
      logic [COUNT_OUT_W-1:0]     entry_count;
   } rsp_type;

   // One item in flight along the chain. key is the search key, or the key
   // being carried upward by an insert once it has displaced a stored one.
   typedef struct packed {
      logic               live;
      logic               search;
      logic               lookup;   // compare only, no store change
      logic               placed;
      logic               done;
      status_type         status;
      logic signed [31:0] key;
   } wave_type;

endpackage
`default_nettype wire

// ----- design/suk_cell.sv -----
// One cell of the sorted unique key table: holds one key and its valid bit,
// and passes the item wave to the next cell each cycle. Uses suk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module suk_cell #(
   parameter int unsigned POS_W = 4,
   parameter int unsigned INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  suk_pkg::wave_type  up_wave,
   input  logic [POS_W-1:0]   up_pos,
   output suk_pkg::wave_type  dn_wave,
   output logic [POS_W-1:0]   dn_pos
);
   import suk_pkg::*;

   logic signed [31:0] key_ff, key_in;
   logic               valid_ff, valid_in;
   wave_type           wave_ff, wave_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               lt, eq;
   logic [POS_W-1:0]   my_pos;

   assign my_pos = POS_W'(INDEX);
   assign lt     = valid_ff && (key_ff < up_wave.key);
   assign eq     = valid_ff && (key_ff == up_wave.key);

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      wave_in  = up_wave;
      pos_in   = up_pos;
      if (up_wave.live && !up_wave.done) begin
         if (up_wave.lookup) begin
            if (eq) begin
               wave_in.done   = 1'b1;
               wave_in.status = up_wave.search ? ST_FOUND : ST_DUPLICATE;
               pos_in         = up_wave.search ? my_pos : '0;
            end else if (!lt) begin
               wave_in.done   = 1'b1;
               wave_in.status = up_wave.search ? ST_NOT_FOUND : ST_FULL;
               pos_in         = '0;
            end
         end else if (!up_wave.placed) begin
            if (eq) begin
               wave_in.done   = 1'b1;
               wave_in.status = ST_DUPLICATE;
               pos_in         = '0;
            end else if (!lt) begin
               // first larger or empty cell: take the key, push the old one up
               key_in         = up_wave.key;
               valid_in       = 1'b1;
               wave_in.placed = 1'b1;
               pos_in         = my_pos;
               if (valid_ff) begin
                  wave_in.key = key_ff;
               end else begin
                  wave_in.done   = 1'b1;
                  wave_in.status = ST_INSERTED;
               end
            end
         end else begin
            key_in   = up_wave.key;
            valid_in = 1'b1;
            if (valid_ff) begin
               wave_in.key = key_ff;
            end else begin
               wave_in.done   = 1'b1;
               wave_in.status = ST_INSERTED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
      if (reset) begin
         valid_ff <= 1'b0;
         wave_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wave_ff  <= wave_in;
      end
   end

   assign dn_wave = wave_ff;
   assign dn_pos  = pos_ff;

endmodule
`default_nettype wire

// ----- design/sorted_unique_key_table.sv -----
// Top level of the sorted unique key table: chain of suk_cell instances,
// item entry, result register and key count. Uses suk_pkg and suk_cell.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to CAPACITY signed keys in ascending order without duplicates.
// Raise start with req_data while busy is low; the item is taken at that edge.
// The item walks the chain of CAPACITY cells, one cell per cycle, comparing,
// inserting and shifting larger keys up as it goes. Its result appears on
// rsp_data with rsp_strobe high for one cycle, and must be captured then;
// rsp_data keeps it until the next result. busy drops with the strobe, so a
// new item is taken only once the previous result is out. An insert into a
// full table reports full (or duplicate, if the key is present) and changes
// nothing. The table is empty after reset.
module sorted_unique_key_table #(
   parameter int unsigned CAPACITY = suk_pkg::DEFAULT_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  suk_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output suk_pkg::rsp_type  rsp_data
);
   import suk_pkg::*;

   localparam int unsigned POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   wave_type          chain [CAPACITY+1];
   logic [POS_W-1:0]  pos_chain [CAPACITY+1];

   logic              busy_ff, busy_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              accept, full;
   wave_type          tail;
   logic [POS_W-1:0]  tail_pos;
   logic [POS_W+POS_OUT_W-1:0]   pos_wide;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      chain[0]        = '0;
      chain[0].live   = accept;
      chain[0].search = (req_data.action == ACT_SEARCH);
      chain[0].lookup = (req_data.action == ACT_SEARCH) || full;
      chain[0].status = ST_INSERTED;
      chain[0].key    = req_data.key;
      pos_chain[0]    = '0;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      suk_cell #(
         .POS_W (POS_W),
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_wave (chain[i]),
         .up_pos  (pos_chain[i]),
         .dn_wave (chain[i+1]),
         .dn_pos  (pos_chain[i+1])
      );
   end

   assign tail     = chain[CAPACITY];
   assign tail_pos = pos_chain[CAPACITY];

   always_comb begin
      busy_in       = busy_ff;
      rsp_strobe_in = 1'b0;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      pos_wide      = '0;
      cnt_wide      = '0;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tail.live) begin
         busy_in       = 1'b0;
         rsp_strobe_in = 1'b1;
         if (tail.done && tail.status == ST_INSERTED) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
         pos_wide = {{POS_OUT_W{1'b0}}, tail_pos};
         cnt_wide = {{COUNT_OUT_W{1'b0}}, count_in};
         if (tail.done) begin
            rsp_in.status         = tail.status;
            rsp_in.match_position = pos_wide[POS_OUT_W-1:0];
         end else begin
            // ran past every stored key without a hit
            rsp_in.status         = tail.search ? ST_NOT_FOUND : ST_FULL;
            rsp_in.match_position = '0;
         end
         rsp_in.entry_count = cnt_wide[COUNT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
         count_ff      <= count_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy_ff)
      else $error("busy still high after result");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(busy_ff))
      else $error("result without an item in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("key count above capacity");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.status == ST_INSERTED)
         |-> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not advance the key count");

endmodule
`default_nettype wire

// ----- tb/sv/sorted_unique_key_table_tb.sv -----
// Testbench for sorted_unique_key_table: directed and random insert/search items
// checked against a behavioral copy of the sorted key set. Uses suk_pkg.
`timescale 1ns / 1ps
module sorted_unique_key_table_tb;
   import suk_pkg::*;

   localparam int unsigned TABLE_CAPACITY = DEFAULT_CAPACITY;
   localparam int unsigned QUIET_LIMIT    = 400;
   localparam int unsigned RANDOM_ITEMS   = 1750;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Behavioral copy of the table: ascending keys, first table_fill meaningful.
   logic signed [31:0] table_keys [TABLE_CAPACITY];
   int                 table_fill;
   rsp_type            pending_results [$];
   rsp_type            oldest_result;
   int unsigned        error_count;
   int unsigned        quiet_cycles;
   bit                 sender_idles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sorted_unique_key_table #(.CAPACITY(TABLE_CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // Apply one item to the table copy and return the result it should give.
   function automatic rsp_type table_apply(req_type item);
      rsp_type outcome;
      int      slot;
      bit      hit;
      slot = 0;
      while (slot < table_fill && table_keys[slot] < item.key)
         slot++;
      hit = (slot < table_fill) && (table_keys[slot] == item.key);
      outcome.match_position = '0;
      if (item.action == ACT_SEARCH) begin
         outcome.status = hit ? ST_FOUND : ST_NOT_FOUND;
         if (hit)
            outcome.match_position = POS_OUT_W'(slot);
      end else if (hit) begin
         outcome.status = ST_DUPLICATE;
      end else if (table_fill >= TABLE_CAPACITY) begin
         outcome.status = ST_FULL;
      end else begin
         for (int i = table_fill; i > slot; i--)
            table_keys[i] = table_keys[i - 1];
         table_keys[slot] = item.key;
         table_fill++;
         outcome.status = ST_INSERTED;
         outcome.match_position = POS_OUT_W'(slot);
      end
      outcome.entry_count = COUNT_OUT_W'(table_fill);
      return outcome;
   endfunction

   function automatic logic signed [31:0] stored_key();
      return table_keys[$urandom_range(0, table_fill - 1)];
   endfunction

   // Mix of fully random keys, stored keys, their neighbors, extremes, zero and -1.
   function automatic logic signed [31:0] pick_key();
      logic signed [31:0] k;
      k = $urandom;
      case ($urandom_range(0, 5))
         2, 3: if (table_fill > 0) k = stored_key();
         4: if (table_fill > 0) k = stored_key() + ($urandom_range(0, 1) ? 1 : -1);
         5: begin
            case ($urandom_range(0, 3))
               0: k = KEY_MIN;
               1: k = KEY_MAX;
               2: k = 32'sd0;
               default: k = -32'sd1;
            endcase
         end
         default: ;
      endcase
      return k;
   endfunction

   // Drive one item and hold it until the block takes it.
   task automatic send_item(input logic act, input logic signed [31:0] key);
      int unsigned gap;
      req_type     item;
      item.action = act;
      item.key    = key;
      gap = sender_idles ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         @(posedge clock);
         while (busy) @(posedge clock);
         repeat (gap - 1) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(table_apply(item));
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      @(posedge clock);
   endtask

   task automatic test_empty_search();
      send_item(ACT_SEARCH, KEY_MIN);
      send_item(ACT_SEARCH, KEY_MAX);
      send_item(ACT_SEARCH, 32'sd0);
      send_item(ACT_SEARCH, -32'sd1);
   endtask

   task automatic test_edge_inserts();
      send_item(ACT_INSERT, 32'sd0);
      send_item(ACT_INSERT, KEY_MAX);
      send_item(ACT_INSERT, KEY_MIN);
      send_item(ACT_INSERT, -32'sd1);
      send_item(ACT_INSERT, 32'sd1);
      send_item(ACT_INSERT, KEY_MAX);
      send_item(ACT_INSERT, KEY_MIN);
      send_item(ACT_SEARCH, KEY_MIN);
      send_item(ACT_SEARCH, KEY_MAX);
      send_item(ACT_SEARCH, 32'sd2);
      send_item(ACT_SEARCH, -32'sd1);
   endtask

   task automatic test_random_fill();
      while (table_fill < TABLE_CAPACITY) begin
         send_item($urandom_range(0, 9) < 7 ? ACT_INSERT : ACT_SEARCH, pick_key());
      end
   endtask

   // Full table: a new key is refused, a present one reports duplicate.
   task automatic test_full_table();
      send_item(ACT_INSERT, 32'sh1234_5678);
      send_item(ACT_INSERT, table_keys[0]);
      send_item(ACT_INSERT, table_keys[TABLE_CAPACITY - 1]);
      send_item(ACT_SEARCH, table_keys[TABLE_CAPACITY - 1]);
      send_item(ACT_SEARCH, KEY_MIN);
   endtask

   task automatic test_random_full();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0)
            sender_idles = ($urandom_range(0, 3) != 0);
         if (i == 500 || $urandom_range(0, 63) == 0)
            wait_for_drain();
         send_item($urandom_range(0, 1) ? ACT_SEARCH : ACT_INSERT, pick_key());
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d", rsp_data.status);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.status !== oldest_result.status) begin
               $error("status: expected %0d, got %0d", oldest_result.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.match_position !== oldest_result.match_position) begin
               $error("match_position: expected %0d, got %0d",
                      oldest_result.match_position, rsp_data.match_position);
               error_count++;
            end
            if (rsp_data.entry_count !== oldest_result.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      oldest_result.entry_count, rsp_data.entry_count);
               error_count++;
            end
         end
      end
   end

   // Count cycles with no accepted item and no result; end the run at QUIET_LIMIT.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("sorted_unique_key_table_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      error_count  = 0;
      quiet_cycles = 0;
      table_fill   = 0;
      sender_idles = 1'b1;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_search();
      test_edge_inserts();
      test_random_fill();
      test_full_table();
      test_random_full();
      wait_for_drain();
      // let any stray result show up
      repeat (2 * TABLE_CAPACITY) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_unique_key_table_tb: done, clean");
      end else begin
         $display("sorted_unique_key_table_tb: done, errors");
      end
      $finish;
   end

endmodule
